FILE: src/differential_odometry_gyro_fusion_top_macros.svh
// Assertion macros for the differential odometry block.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef DIFFERENTIAL_ODOMETRY_GYRO_FUSION_TOP_MACROS_SVH
`define DIFFERENTIAL_ODOMETRY_GYRO_FUSION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define DOGF_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// Condition must never be seen outside reset.
`define DOGF_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define DOGF_ASSERT(name, clk, rst_n, prop, msg)
`define DOGF_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

FILE: src/dogf_pkg.sv
// Shared types, constants and helper functions of the differential odometry block.
// No dependencies; every module file imports this package.
package dogf_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	// serial divider geometry
	localparam int DIV_NUM_W = 56;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_BITS  = 8;

	// shared multiplier geometry
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// 0.02 s step in Q8.24 from Q7.16 rate: times 128, over 25
	localparam logic [DIV_DEN_W-1:0] GYRO_DEN = 16'd25;

	localparam logic [15:0]        TPR_RST  = 16'd360;
	localparam logic [15:0]        CIRC_RST = 16'd2573;
	localparam logic [15:0]        BASE_RST = 16'd2048;
	localparam logic [15:0]        EW_RST   = 16'd16384;
	localparam logic [15:0]        GW_RST   = 16'd16384;
	localparam logic signed [23:0] GOFF_RST = 24'sd0;

	typedef enum logic [1:0] {
		CMD_LEFT   = 2'd0,
		CMD_RIGHT  = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_TICKS_PER_REV = 3'd0,
		CFG_WHEEL_CIRC    = 3'd1,
		CFG_WHEEL_BASE    = 3'd2,
		CFG_ENC_WEIGHT    = 3'd3,
		CFG_GYRO_WEIGHT   = 3'd4,
		CFG_GYRO_OFFSET   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              enc_b;
		logic signed [23:0] gyro_z;
		logic              gyro_ok;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] heading_out;
		logic signed [31:0] distance_out;
		logic signed [31:0] left_out;
		logic signed [31:0] right_out;
	} out_word_t;

	typedef struct packed {
		logic [15:0]        ticks_per_rev;
		logic [15:0]        wheel_circumference;
		logic [15:0]        wheel_base;
		logic [15:0]        encoder_weight;
		logic [15:0]        gyro_weight;
		logic signed [23:0] gyro_offset;
	} cfg_t;

	// classified queue entry: up is the count direction of an edge
	typedef struct packed {
		cmd_t               cmd;
		logic               up;
		logic signed [23:0] gyro_z;
		logic               gyro_ok;
	} step_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	// apply sign to a quotient magnitude and clamp to 32 bit signed
	function automatic logic signed [31:0] sat_mag(input logic neg,
			input logic [DIV_NUM_W-1:0] mag);
		logic big;
		logic [31:0] low;
		big = (mag[DIV_NUM_W-1:32] != '0);
		low = mag[31:0];
		if (!neg) begin
			if (big || low[31])
				return 32'sh7fffffff;
			return signed'(low);
		end
		if (big || (low[31] && (low[30:0] != '0)))
			return 32'sh80000000;
		return signed'(32'(-low));
	endfunction

	// clamp a 37 bit signed value to 32 bit signed
	function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
		if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111))
			return signed'(v[31:0]);
		if (v[36])
			return 32'sh80000000;
		return 32'sh7fffffff;
	endfunction

endpackage

FILE: src/dogf_div.sv
// Restoring divider, DIV_BITS quotient bits per cycle, unsigned operands.
// Uses dogf_pkg for its geometry and request/response types.
module dogf_div import dogf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEPS = DIV_NUM_W / DIV_BITS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DIV_NUM_W-1:0] work_q, work_n;
	logic [DIV_DEN_W-1:0] rem_q, rem_n, den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q;

	always_comb begin
		logic [DIV_DEN_W:0] trial;
		rem_n  = rem_q;
		work_n = work_q;
		trial  = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial  = {rem_n, work_n[DIV_NUM_W-1]};
			work_n = {work_n[DIV_NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_n     = DIV_DEN_W'(trial - {1'b0, den_q});
				work_n[0] = 1'b1;
			end else begin
				rem_n = trial[DIV_DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = work_q;

endmodule

FILE: src/dogf_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
// Uses dogf_pkg for the word and queue entry types.
module dogf_front import dogf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	output logic     q_valid,
	output step_t    q_item,
	input  logic     q_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	step_t            ent_q [QUEUE_DEPTH];
	step_t            step;
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;

	assign in_stall = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = ent_q[rd_q];

	// left counts up on B low, right counts up on B high
	always_comb begin
		step.cmd     = in_data.cmd;
		step.up      = (in_data.cmd == CMD_RIGHT) ? in_data.enc_b : !in_data.enc_b;
		step.gyro_z  = in_data.gyro_z;
		step.gyro_ok = in_data.gyro_ok;
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: src/dogf_back.sv
// Back end: executes queued commands, owns the odometry state and the output register.
// Uses dogf_pkg and instantiates dogf_div for the wheel, heading and gyro divisions.
module dogf_back import dogf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  step_t     q_item,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'h0001,
		ST_MUL_L  = 15'h0002,
		ST_GO_L   = 15'h0004,
		ST_DIV_L  = 15'h0008,
		ST_MUL_R  = 15'h0010,
		ST_GO_R   = 15'h0020,
		ST_DIV_R  = 15'h0040,
		ST_GO_E   = 15'h0080,
		ST_DIV_E  = 15'h0100,
		ST_GO_G   = 15'h0200,
		ST_DIV_G  = 15'h0400,
		ST_MUL_H1 = 15'h0800,
		ST_MUL_H2 = 15'h1000,
		ST_SUM    = 15'h2000,
		ST_DONE   = 15'h4000
	} state_t;

	state_t state_q;

	logic [COUNT_WIDTH-1:0] left_q, right_q, prev_l_q, prev_r_q;
	logic [COUNT_WIDTH-1:0] left_n, right_n, dl_raw, dr_raw;
	logic signed [31:0]     head_q, dist_q, head_n, dist_n;
	logic signed [31:0]     dl_q, dr_q, l_q, r_q, enc_q, gyr_q, avg_q;
	logic signed [23:0]     gz_q;
	logic                   gok_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p, prod_q, acc_q;
	logic signed [PROD_W:0]    sum_q, biased, shifted;

	logic [31:0]        dl_mag, dr_mag;
	logic signed [32:0] ediff, lr_sum;
	logic [32:0]        emag;
	logic signed [24:0] gdiff;
	logic [24:0]        gmag;
	logic signed [32:0] dist_sum;
	logic [15:0]        tpr_eff, base_eff;

	div_req_t  dreq;
	div_rsp_t  drsp;
	out_word_t out_q, out_n;
	logic      out_valid_q, out_free, out_load, is_clear;

	dogf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign tpr_eff  = (cfg.ticks_per_rev == '0) ? 16'd1 : cfg.ticks_per_rev;
	assign base_eff = (cfg.wheel_base == '0) ? 16'd1 : cfg.wheel_base;

	assign dl_raw = left_q - prev_l_q;
	assign dr_raw = right_q - prev_r_q;
	assign dl_mag = dl_q[31] ? 32'(-dl_q) : 32'(dl_q);
	assign dr_mag = dr_q[31] ? 32'(-dr_q) : 32'(dr_q);

	assign ediff  = 33'(r_q) - 33'(l_q);
	assign emag   = ediff[32] ? 33'(-ediff) : 33'(ediff);
	assign lr_sum = 33'(l_q) + 33'(r_q);
	assign gdiff  = 25'(gz_q) - 25'(cfg.gyro_offset);
	assign gmag   = gdiff[24] ? 25'(-gdiff) : 25'(gdiff);

	// divide by 32768 rounding toward zero, then clamp
	assign biased   = sum_q + (sum_q[PROD_W] ? (PROD_W + 1)'(32767) : '0);
	assign shifted  = biased >>> 15;
	assign head_n   = sat37(shifted[36:0]);
	assign dist_sum = 33'(dist_q) + 33'(avg_q);
	assign dist_n   = sat37(37'(dist_sum));

	// shared multiplier, product registered every cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_L: begin
				mul_a = signed'({2'b00, dl_mag});
				mul_b = signed'({1'b0, cfg.wheel_circumference});
			end
			ST_MUL_R: begin
				mul_a = signed'({2'b00, dr_mag});
				mul_b = signed'({1'b0, cfg.wheel_circumference});
			end
			ST_MUL_H1: begin
				mul_a = MUL_A_W'(head_q) + MUL_A_W'(enc_q);
				mul_b = signed'({1'b0, cfg.encoder_weight});
			end
			ST_MUL_H2: begin
				mul_a = MUL_A_W'(head_q) + MUL_A_W'(gyr_q);
				mul_b = signed'({1'b0, cfg.gyro_weight});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = tpr_eff;
		case (state_q)
			ST_GO_L, ST_GO_R: begin
				dreq.start = 1'b1;
				dreq.num   = {prod_q[47:0], 8'b0};
				dreq.den   = tpr_eff;
			end
			ST_GO_E: begin
				dreq.start = 1'b1;
				dreq.num   = {7'b0, emag, 16'b0};
				dreq.den   = base_eff;
			end
			ST_GO_G: begin
				dreq.start = gok_q;
				dreq.num   = {24'b0, gmag, 7'b0};
				dreq.den   = GYRO_DEN;
			end
			default: begin
				dreq.start = 1'b0;
				dreq.num   = '0;
				dreq.den   = tpr_eff;
			end
		endcase
	end

	always_comb begin
		left_n  = left_q;
		right_n = right_q;
		case (q_item.cmd)
			CMD_LEFT:  left_n  = q_item.up ? left_q + 1'b1 : left_q - 1'b1;
			CMD_RIGHT: right_n = q_item.up ? right_q + 1'b1 : right_q - 1'b1;
			default: begin
				left_n  = left_q;
				right_n = right_q;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && q_valid &&
		((q_item.cmd == CMD_UPDATE) || out_free);
	assign is_clear = (q_item.cmd == CMD_CLEAR);

	always_comb begin
		out_load = 1'b0;
		out_n    = out_q;
		if (state_q == ST_IDLE) begin
			out_load           = q_pop && (q_item.cmd != CMD_UPDATE);
			out_n.heading_out  = is_clear ? '0 : head_q;
			out_n.distance_out = is_clear ? '0 : dist_q;
			out_n.left_out     = is_clear ? '0 : 32'(signed'(left_n));
			out_n.right_out    = is_clear ? '0 : 32'(signed'(right_n));
		end else if (state_q == ST_DONE) begin
			out_load           = out_free;
			out_n.heading_out  = head_n;
			out_n.distance_out = dist_n;
			out_n.left_out     = 32'(signed'(left_q));
			out_n.right_out    = 32'(signed'(right_q));
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (out_load)
			out_q <= out_n;
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					dl_q  <= 32'(signed'(dl_raw));
					dr_q  <= 32'(signed'(dr_raw));
					gz_q  <= q_item.gyro_z;
					gok_q <= q_item.gyro_ok;
				end
			end
			ST_DIV_L: begin
				if (drsp.done)
					l_q <= sat_mag(dl_q[31], drsp.quo);
			end
			ST_DIV_R: begin
				if (drsp.done)
					r_q <= sat_mag(dr_q[31], drsp.quo);
			end
			ST_GO_E: begin
				avg_q <= 32'((lr_sum + 33'(lr_sum[32])) >>> 1);
			end
			ST_DIV_E: begin
				if (drsp.done)
					enc_q <= sat_mag(ediff[32], drsp.quo);
			end
			ST_GO_G: begin
				if (!gok_q)
					gyr_q <= '0;
			end
			ST_DIV_G: begin
				if (drsp.done)
					gyr_q <= sat_mag(gdiff[24], drsp.quo);
			end
			ST_MUL_H2: begin
				acc_q <= prod_q;
			end
			ST_SUM: begin
				sum_q <= (PROD_W + 1)'(acc_q) + (PROD_W + 1)'(prod_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= '0;
			right_q     <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			head_q      <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.cmd)
							CMD_LEFT, CMD_RIGHT: begin
								left_q  <= left_n;
								right_q <= right_n;
							end
							CMD_UPDATE: begin
								prev_l_q <= left_q;
								prev_r_q <= right_q;
								state_q  <= ST_MUL_L;
							end
							default: begin
								left_q   <= '0;
								right_q  <= '0;
								prev_l_q <= '0;
								prev_r_q <= '0;
								head_q   <= '0;
								dist_q   <= '0;
							end
						endcase
					end
				end
				ST_MUL_L:  state_q <= ST_GO_L;
				ST_GO_L:   state_q <= ST_DIV_L;
				ST_DIV_L:  if (drsp.done) state_q <= ST_MUL_R;
				ST_MUL_R:  state_q <= ST_GO_R;
				ST_GO_R:   state_q <= ST_DIV_R;
				ST_DIV_R:  if (drsp.done) state_q <= ST_GO_E;
				ST_GO_E:   state_q <= ST_DIV_E;
				ST_DIV_E:  if (drsp.done) state_q <= ST_GO_G;
				ST_GO_G:   state_q <= gok_q ? ST_DIV_G : ST_MUL_H1;
				ST_DIV_G:  if (drsp.done) state_q <= ST_MUL_H1;
				ST_MUL_H1: state_q <= ST_MUL_H2;
				ST_MUL_H2: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						head_q  <= head_n;
						dist_q  <= dist_n;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/differential_odometry_gyro_fusion_top.sv
// Wheel encoder odometry with gyro heading fusion. Every input word gives
// exactly one output word holding heading (Q8.24 rad), distance (Q16.16 cm)
// and both tick counts after the command. A two-entry queue separates the
// input from the execution unit, and an output register separates that unit
// from the consumer, so input words can still queue while a result waits.
// Encoder edges and clears finish in the idle state once the output
// register is free. An update tick uses the shared divider (8 quotient
// bits per cycle) for left travel, right travel, encoder heading and,
// with a valid gyro sample, the gyro step, and the shared multiplier for
// each blended heading term. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block does not enforce; higher indexes are ignored.
// Uses dogf_pkg, dogf_front, dogf_back and the assertion macro header.
`include "differential_odometry_gyro_fusion_top_macros.svh"

module differential_odometry_gyro_fusion_top import dogf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid, q_pop;
	step_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_rev       <= TPR_RST;
			cfg_q.wheel_circumference <= CIRC_RST;
			cfg_q.wheel_base          <= BASE_RST;
			cfg_q.encoder_weight      <= EW_RST;
			cfg_q.gyro_weight         <= GW_RST;
			cfg_q.gyro_offset         <= GOFF_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TICKS_PER_REV: cfg_q.ticks_per_rev       <= cfg_data[15:0];
				CFG_WHEEL_CIRC:    cfg_q.wheel_circumference <= cfg_data[15:0];
				CFG_WHEEL_BASE:    cfg_q.wheel_base          <= cfg_data[15:0];
				CFG_ENC_WEIGHT:    cfg_q.encoder_weight      <= cfg_data[15:0];
				CFG_GYRO_WEIGHT:   cfg_q.gyro_weight         <= cfg_data[15:0];
				CFG_GYRO_OFFSET:   cfg_q.gyro_offset         <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	dogf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	dogf_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`DOGF_ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_valid, "pop from empty queue")
	`DOGF_ASSERT(a_in_queued, clk, arst_n, in_valid && !in_stall |=> q_valid, "accepted word not queued")
	`DOGF_ASSERT(a_cfg_tpr, clk, arst_n, cfg_we && (cfg_index == CFG_TICKS_PER_REV) |=> cfg_q.ticks_per_rev == $past(cfg_data[15:0]), "ticks_per_rev write lost")

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the differential odometry top: random-gap word driver,
// stalling result monitor and an in-bench model of ticks, travel, heading and distance.
// Depends on dogf_pkg and differential_odometry_gyro_fusion_top.
module testbench;
	import dogf_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	logic      cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_TICKS_PER_REV;
	logic [23:0] cfg_data = '0;

	differential_odometry_gyro_fusion_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// odometry model state and its copy of the registers
	cfg_t        cur_cfg = '{TPR_RST, CIRC_RST, BASE_RST, EW_RST, GW_RST, GOFF_RST};
	logic [31:0] cnt_left = '0;
	logic [31:0] cnt_right = '0;
	logic [31:0] last_left = '0;
	logic [31:0] last_right = '0;
	longint      heading_q = 0;
	longint      distance_q = 0;

	in_word_t  pending_cmds[$];
	out_word_t expected_odo[$];
	int        mismatch_count = 0;
	int        result_count = 0;
	int        send_gap = 0;
	int        recv_wait = 0;
	int        hold_left = 0;
	int        idle_cycles = 0;
	bit        send_calm = 1'b0;
	bit        recv_calm = 1'b0;

	function automatic longint sat_i32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q16.16 cm of travel for a signed tick delta
	function automatic longint travel_q16(input longint d);
		longint tpr;
		longint circ;
		tpr = cur_cfg.ticks_per_rev;
		circ = cur_cfg.wheel_circumference;
		if (tpr == 0)
			tpr = 1;
		return sat_i32(d * circ * 256 / tpr);
	endfunction

	function automatic out_word_t advance_odometry(input in_word_t w);
		out_word_t o;
		logic signed [31:0] step_l;
		logic signed [31:0] step_r;
		longint dl, dr, tl, tr, avg, div_base, enc, gyr, gz, off, ew, gw;
		case (w.cmd)
			CMD_LEFT: begin
				cnt_left = w.enc_b ? cnt_left - 32'd1 : cnt_left + 32'd1;
			end
			CMD_RIGHT: begin
				cnt_right = w.enc_b ? cnt_right + 32'd1 : cnt_right - 32'd1;
			end
			CMD_UPDATE: begin
				step_l = cnt_left - last_left;
				step_r = cnt_right - last_right;
				last_left = cnt_left;
				last_right = cnt_right;
				dl = step_l;
				dr = step_r;
				tl = travel_q16(dl);
				tr = travel_q16(dr);
				avg = (tl + tr) / 2;
				div_base = cur_cfg.wheel_base;
				if (div_base == 0)
					div_base = 1;
				enc = sat_i32((tr - tl) * 65536 / div_base);
				gyr = 0;
				if (w.gyro_ok) begin
					gz = w.gyro_z;
					off = cur_cfg.gyro_offset;
					gyr = (gz - off) * 128 / 25;
				end
				ew = cur_cfg.encoder_weight;
				gw = cur_cfg.gyro_weight;
				heading_q = sat_i32((ew * (heading_q + enc) + gw * (heading_q + gyr)) / 32768);
				distance_q = sat_i32(distance_q + avg);
			end
			default: begin
				cnt_left = '0;
				cnt_right = '0;
				last_left = '0;
				last_right = '0;
				heading_q = 0;
				distance_q = 0;
			end
		endcase
		o.heading_out = heading_q[31:0];
		o.distance_out = distance_q[31:0];
		o.left_out = cnt_left;
		o.right_out = cnt_right;
		return o;
	endfunction

	// word driver: hold the word until taken, then wait a random gap before the next
	always @(posedge clk or negedge arst_n) begin
		int g;
		logic free;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			g = send_gap;
			free = !in_valid;
			if (in_valid && !in_stall) begin
				expected_odo.push_back(advance_odometry(in_data));
				free = 1'b1;
				g = send_calm ? 0 : $urandom_range(0, 4);
			end
			if (free) begin
				if (g == 0 && pending_cmds.size() != 0) begin
					in_data <= pending_cmds.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					if (g > 0)
						g--;
				end
			end
			send_gap <= g;
		end
	end

	task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
		end
	endtask

	// result monitor: stall for a random gap after each word, plus two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		int s;
		int h;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
			hold_left <= 0;
		end else begin
			s = recv_wait;
			h = hold_left;
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_odo.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 40)
						$display("%0t: unexpected word: expected none, actual %h", $time, out_data);
				end else begin
					want = expected_odo.pop_front();
					check_field("heading_out", want.heading_out, out_data.heading_out);
					check_field("distance_out", want.distance_out, out_data.distance_out);
					check_field("left_out", want.left_out, out_data.left_out);
					check_field("right_out", want.right_out, out_data.right_out);
				end
				s = recv_calm ? 0 : $urandom_range(0, 4);
				// back up the block until the input stalls
				if (result_count == 120 || result_count == 450)
					h = 300;
			end
			if (h > 0) begin
				out_stall <= 1'b1;
				h--;
			end else if (s > 0) begin
				out_stall <= 1'b1;
				s--;
			end else begin
				out_stall <= 1'b0;
			end
			recv_wait <= s;
			hold_left <= h;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= 5000) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_cmd(input cmd_t c, input logic b, input logic [23:0] gz, input logic ok);
		in_word_t w;
		w.cmd = c;
		w.enc_b = b;
		w.gyro_z = gz;
		w.gyro_ok = ok;
		pending_cmds.push_back(w);
	endtask

	task automatic set_reg(input cfg_idx_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TICKS_PER_REV: cur_cfg.ticks_per_rev = val[15:0];
			CFG_WHEEL_CIRC:    cur_cfg.wheel_circumference = val[15:0];
			CFG_WHEEL_BASE:    cur_cfg.wheel_base = val[15:0];
			CFG_ENC_WEIGHT:    cur_cfg.encoder_weight = val[15:0];
			CFG_GYRO_WEIGHT:   cur_cfg.gyro_weight = val[15:0];
			default:           cur_cfg.gyro_offset = val;
		endcase
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || expected_odo.size() != 0);
	endtask

	// mostly edge bursts closed by an update tick, some stray words
	task automatic queue_random(input int count);
		int made;
		int burst;
		int k;
		logic lean;
		cmd_t side;
		made = 0;
		@(negedge clk);
		while (made < count) begin
			if ($urandom_range(0, 9) == 0) begin
				push_cmd(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					24'($urandom()), 1'($urandom_range(0, 1)));
				made++;
			end else begin
				burst = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 140)
					: $urandom_range(0, 8);
				lean = 1'($urandom_range(0, 1));
				for (k = 0; k < burst; k++) begin
					side = $urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT;
					if ($urandom_range(0, 3) == 0)
						push_cmd(side, 1'($urandom_range(0, 1)), 24'($urandom()), 1'($urandom_range(0, 1)));
					else
						push_cmd(side, lean ^ (side == CMD_LEFT), 24'($urandom()), 1'($urandom_range(0, 1)));
				end
				push_cmd(CMD_UPDATE, 1'($urandom_range(0, 1)), 24'($urandom()),
					1'($urandom_range(0, 4) != 0));
				made += burst + 1;
			end
		end
	endtask

	initial begin
		cfg_t plan;
		int p;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// edge directions, wrap below zero, gyro extremes and invalid gyro, clear
		push_cmd(CMD_LEFT, 1'b0, 24'h000000, 1'b0);
		push_cmd(CMD_LEFT, 1'b1, 24'h000000, 1'b0);
		push_cmd(CMD_LEFT, 1'b1, 24'hffffff, 1'b1);
		push_cmd(CMD_RIGHT, 1'b1, 24'h000000, 1'b0);
		push_cmd(CMD_RIGHT, 1'b0, 24'h000000, 1'b0);
		push_cmd(CMD_RIGHT, 1'b0, 24'hffffff, 1'b1);
		push_cmd(CMD_UPDATE, 1'b0, 24'h7fffff, 1'b1);
		push_cmd(CMD_UPDATE, 1'b1, 24'h800000, 1'b1);
		push_cmd(CMD_UPDATE, 1'b0, 24'h123456, 1'b0);
		repeat (3) push_cmd(CMD_LEFT, 1'b0, 24'h000000, 1'b0);
		repeat (2) push_cmd(CMD_RIGHT, 1'b1, 24'h000000, 1'b0);
		push_cmd(CMD_UPDATE, 1'b0, 24'hffffff, 1'b1);
		push_cmd(CMD_CLEAR, 1'b1, 24'h7fffff, 1'b1);
		push_cmd(CMD_RIGHT, 1'b1, 24'h000000, 1'b0);
		push_cmd(CMD_UPDATE, 1'b1, 24'h800000, 1'b0);
		push_cmd(CMD_LEFT, 1'b1, 24'h000000, 1'b0);
		push_cmd(CMD_LEFT, 1'b1, 24'h000000, 1'b0);
		push_cmd(CMD_UPDATE, 1'b0, 24'($urandom()), 1'b1);
		push_cmd(CMD_CLEAR, 1'b0, 24'h000000, 1'b0);
		drain();

		for (p = 0; p < 7; p++) begin
			case (p)
				0: begin
					plan.ticks_per_rev = 16'($urandom_range(100, 2000));
					plan.wheel_circumference = 16'($urandom_range(1000, 5000));
					plan.wheel_base = 16'($urandom_range(1000, 8000));
					plan.encoder_weight = 16'($urandom_range(0, 32768));
					plan.gyro_weight = 16'd32768 - plan.encoder_weight;
					plan.gyro_offset = 24'($urandom_range(0, 2000)) - 24'd1000;
				end
				// zero divisors, weights above one, most negative bias
				1: plan = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd65535, 24'h800000};
				2: plan = '{16'd65535, 16'd1, 16'd65535, 16'd0, 16'd32768, 24'h7fffff};
				3: plan = '{16'd1, 16'd65535, 16'd1, 16'd32768, 16'd0, 24'($urandom())};
				default: begin
					plan.ticks_per_rev = 16'($urandom_range(0, 65535));
					plan.wheel_circumference = 16'($urandom_range(0, 65535));
					plan.wheel_base = 16'($urandom_range(0, 65535));
					plan.encoder_weight = 16'($urandom_range(0, 40000));
					plan.gyro_weight = 16'($urandom_range(0, 40000));
					plan.gyro_offset = 24'($urandom());
				end
			endcase
			set_reg(CFG_TICKS_PER_REV, {8'd0, plan.ticks_per_rev});
			set_reg(CFG_WHEEL_CIRC, {8'd0, plan.wheel_circumference});
			set_reg(CFG_WHEEL_BASE, {8'd0, plan.wheel_base});
			set_reg(CFG_ENC_WEIGHT, {8'd0, plan.encoder_weight});
			set_reg(CFG_GYRO_WEIGHT, {8'd0, plan.gyro_weight});
			set_reg(CFG_GYRO_OFFSET, plan.gyro_offset);
			@(posedge clk);
			cfg_we <= 1'b0;
			send_calm <= (p == 2);
			recv_calm <= (p == 4);
			queue_random(100);
			drain();
		end

		repeat (64) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/dogf_pkg.sv
src/dogf_div.sv
src/dogf_front.sv
src/dogf_back.sv
src/differential_odometry_gyro_fusion_top.sv
tb/testbench.sv
